/* rtl/pixel_color_space_converter_defines.svh */
// Assertion macros used by the checker file.
`ifndef PIXEL_COLOR_SPACE_CONVERTER_DEFINES_SVH
`define PIXEL_COLOR_SPACE_CONVERTER_DEFINES_SVH

// Same-cycle implication.
`define PCSC_ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("pcsc: implication check failed");

// Next-cycle implication.
`define PCSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("pcsc: next-cycle check failed");

`endif

/* rtl/pcsc_pkg.sv */
package pcsc_pkg;

	localparam int CHANNELS       = 3;
	localparam int CMD_BITS       = 2;
	localparam int CODE_BITS      = 8;
	localparam int INDEX_BITS     = 12;
	localparam int VALUE_BITS     = 16;
	localparam int COEF_BITS      = 18;
	localparam int COEF_FRAC      = 14;
	localparam int ROW_BITS       = CHANNELS * COEF_BITS;
	localparam int CFG_INDEX_BITS = 2;
	localparam int DEGAMMA_DEPTH  = 1 << CODE_BITS;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = 2;

	// identity matrix rows, 1.0 = 1 << COEF_FRAC
	localparam logic [ROW_BITS-1:0] ROW_RED_RESET   = ROW_BITS'(1) << COEF_FRAC;
	localparam logic [ROW_BITS-1:0] ROW_GREEN_RESET = ROW_BITS'(1) << (COEF_BITS + COEF_FRAC);
	localparam logic [ROW_BITS-1:0] ROW_BLUE_RESET  =
		ROW_BITS'(1) << (2 * COEF_BITS + COEF_FRAC);

	typedef enum logic [CMD_BITS-1:0] {
		CMD_CONVERT = 2'd0,
		CMD_DEGAMMA = 2'd1,
		CMD_REGAMMA = 2'd2
	} cmd_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROW_RED   = 2'd0,
		REG_ROW_GREEN = 2'd1,
		REG_ROW_BLUE  = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_DEGAMMA = 2'd1,
		KIND_REGAMMA = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [CODE_BITS-1:0]  in_red;
		logic [CODE_BITS-1:0]  in_green;
		logic [CODE_BITS-1:0]  in_blue;
		logic [INDEX_BITS-1:0] table_index;
		logic [VALUE_BITS-1:0] table_value;
	} pcsc_item_t;

	typedef struct packed {
		logic       valid;
		pcsc_item_t item;
	} pcsc_word_t;

endpackage

/* rtl/pcsc_if.sv */
interface pcsc_in_if import pcsc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CMD_BITS-1:0]   cmd;
	logic [CODE_BITS-1:0]  in_red;
	logic [CODE_BITS-1:0]  in_green;
	logic [CODE_BITS-1:0]  in_blue;
	logic [INDEX_BITS-1:0] table_index;
	logic [VALUE_BITS-1:0] table_value;

	modport source (output valid, cmd, in_red, in_green, in_blue, table_index, table_value,
		input ready);
	modport sink (input valid, cmd, in_red, in_green, in_blue, table_index, table_value,
		output ready);
endinterface

interface pcsc_out_if import pcsc_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] out_red;
	logic [CODE_BITS-1:0] out_green;
	logic [CODE_BITS-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface pcsc_cfg_if import pcsc_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [ROW_BITS-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pcsc_ram.sv */
module pcsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/pcsc_front.sv */
module pcsc_front import pcsc_pkg::*; (
	pcsc_in_if.sink    pixel,
	input  logic       full,
	output pcsc_word_t push
);

	logic take;

	assign pixel.ready = !full;
	assign take        = pixel.valid && !full;

	always_comb begin
		push.item.in_red      = pixel.in_red;
		push.item.in_green    = pixel.in_green;
		push.item.in_blue     = pixel.in_blue;
		push.item.table_index = pixel.table_index;
		push.item.table_value = pixel.table_value;
		push.item.kind        = KIND_PIXEL;
		push.valid            = 1'b0;
		case (cmd_t'(pixel.cmd))
			CMD_CONVERT: begin
				push.valid = take;
			end
			CMD_DEGAMMA: begin
				push.valid     = take;
				push.item.kind = KIND_DEGAMMA;
			end
			CMD_REGAMMA: begin
				push.valid     = take;
				push.item.kind = KIND_REGAMMA;
			end
			default: begin
				// unused command: taken and dropped
				push.valid = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/pcsc_queue.sv */
module pcsc_queue import pcsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pcsc_word_t push,
	input  logic       pop,
	output pcsc_word_t head,
	output logic       full
);

	pcsc_item_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign full       = count_q == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
	assign head.valid = count_q != '0;
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.item;
		end
	end

endmodule

/* rtl/pcsc_back.sv */
module pcsc_back import pcsc_pkg::*; #(
	parameter int LINEAR_BITS        = 16,
	parameter int REGAMMA_INDEX_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pcsc_word_t                         head,
	output logic                               pop,
	input  logic [CHANNELS-1:0][ROW_BITS-1:0]  rows,
	pcsc_out_if.source                         result
);

	localparam int ProdW     = LINEAR_BITS + COEF_BITS + 1;
	localparam int SumW      = ProdW + 2;
	localparam int RgDepth   = 1 << REGAMMA_INDEX_BITS;
	localparam int ScaledW   = LINEAR_BITS + REGAMMA_INDEX_BITS;

	logic adv;
	logic dg_we;
	logic rg_we;

	logic                          valid_s1;
	logic                          valid_s2;
	logic                          valid_s3;
	logic                          pix_s3;
	kind_t                         kind_s1;
	kind_t                         kind_s2;
	logic [REGAMMA_INDEX_BITS-1:0] rg_idx_s1;
	logic [REGAMMA_INDEX_BITS-1:0] rg_idx_s2;
	logic [CODE_BITS-1:0]          rg_val_s1;
	logic [CODE_BITS-1:0]          rg_val_s2;

	logic [CODE_BITS-1:0]          pix_code [CHANNELS];
	logic [LINEAR_BITS-1:0]        lin      [CHANNELS];
	logic [CODE_BITS-1:0]          code     [CHANNELS];
	logic signed [ProdW-1:0]       prod_s2  [CHANNELS][CHANNELS];
	logic signed [SumW-1:0]        sum      [CHANNELS];
	logic [LINEAR_BITS-1:0]        lin_out  [CHANNELS];
	logic [ScaledW-1:0]            scaled   [CHANNELS];
	logic [REGAMMA_INDEX_BITS-1:0] rg_addr  [CHANNELS];

	// whole back end freezes while a result waits
	assign adv   = !result.valid || result.ready;
	assign pop   = adv && head.valid;
	assign dg_we = pop && head.item.kind == KIND_DEGAMMA;
	assign rg_we = adv && valid_s2 && kind_s2 == KIND_REGAMMA;

	assign pix_code[0] = head.item.in_red;
	assign pix_code[1] = head.item.in_green;
	assign pix_code[2] = head.item.in_blue;

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
		pcsc_ram #(
			.WIDTH(LINEAR_BITS),
			.DEPTH(DEGAMMA_DEPTH)
		) u_degamma (
			.clk  (clk),
			.we   (dg_we),
			.waddr(head.item.table_index[CODE_BITS-1:0]),
			.wdata(LINEAR_BITS'(head.item.table_value)),
			.re   (adv),
			.raddr(pix_code[ch]),
			.rdata(lin[ch])
		);

		pcsc_ram #(
			.WIDTH(CODE_BITS),
			.DEPTH(RgDepth)
		) u_regamma (
			.clk  (clk),
			.we   (rg_we),
			.waddr(rg_idx_s2),
			.wdata(rg_val_s2),
			.re   (adv),
			.raddr(rg_addr[ch]),
			.rdata(code[ch])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			pix_s3   <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			pix_s3   <= kind_s2 == KIND_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1   <= head.item.kind;
			rg_idx_s1 <= REGAMMA_INDEX_BITS'(head.item.table_index);
			rg_val_s1 <= head.item.table_value[CODE_BITS-1:0];
			kind_s2   <= kind_s1;
			rg_idx_s2 <= rg_idx_s1;
			rg_val_s2 <= rg_val_s1;
			for (int r = 0; r < CHANNELS; r++) begin
				for (int c = 0; c < CHANNELS; c++) begin
					prod_s2[r][c] <= $signed(rows[r][c*COEF_BITS +: COEF_BITS])
						* $signed({1'b0, lin[c]});
				end
			end
		end
	end

	// row sum, floor shift, clamp, top bits form the regamma address
	always_comb begin
		for (int r = 0; r < CHANNELS; r++) begin
			sum[r] = SumW'(prod_s2[r][0]) + SumW'(prod_s2[r][1]) + SumW'(prod_s2[r][2]);
			if (sum[r][SumW-1]) begin
				lin_out[r] = '0;
			end else if (|sum[r][SumW-2:COEF_FRAC+LINEAR_BITS]) begin
				lin_out[r] = '1;
			end else begin
				lin_out[r] = sum[r][COEF_FRAC+LINEAR_BITS-1:COEF_FRAC];
			end
			scaled[r]  = {lin_out[r], {REGAMMA_INDEX_BITS{1'b0}}};
			rg_addr[r] = scaled[r][ScaledW-1 -: REGAMMA_INDEX_BITS];
		end
	end

	assign result.valid     = valid_s3 && pix_s3;
	assign result.out_red   = code[0];
	assign result.out_green = code[1];
	assign result.out_blue  = code[2];

endmodule

/* rtl/pixel_color_space_converter.sv */
// Channel  Role    Payload
// pixel    input   cmd, in_red, in_green, in_blue, table_index, table_value
// result   output  out_red, out_green, out_blue
// cfg      input   index, data (matrix rows, always ready)
//
// One word per clock sustained while results are not stalled; a taken pixel is queued, then staged to the output.
// A 4-word queue separates intake from the 3-stage back end (degamma read,
// multiply, sum/clamp/regamma read), whose regamma read register is the output.
// Stalled results freeze the back end; intake continues until the queue fills.
// Reset clears control and restores identity rows; tables are undefined until written.
module pixel_color_space_converter import pcsc_pkg::*; #(
	parameter int LINEAR_BITS        = 16,
	parameter int REGAMMA_INDEX_BITS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	pcsc_in_if.sink    pixel,
	pcsc_out_if.source result,
	pcsc_cfg_if.sink   cfg
);

	logic [CHANNELS-1:0][ROW_BITS-1:0] rows_q;
	pcsc_word_t                        push;
	pcsc_word_t                        head;
	logic                              full;
	logic                              pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[0] <= ROW_RED_RESET;
			rows_q[1] <= ROW_GREEN_RESET;
			rows_q[2] <= ROW_BLUE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (reg_index_t'(cfg.index))
				REG_ROW_RED:   rows_q[0] <= cfg.data;
				REG_ROW_GREEN: rows_q[1] <= cfg.data;
				REG_ROW_BLUE:  rows_q[2] <= cfg.data;
				default:       ;
			endcase
		end
	end

	pcsc_front u_front (
		.pixel(pixel),
		.full (full),
		.push (push)
	);

	pcsc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.full  (full)
	);

	pcsc_back #(
		.LINEAR_BITS       (LINEAR_BITS),
		.REGAMMA_INDEX_BITS(REGAMMA_INDEX_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.rows  (rows_q),
		.result(result)
	);

endmodule

/* rtl/pcsc_checker.sv */
`include "pixel_color_space_converter_defines.svh"

module pcsc_checker import pcsc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [CMD_BITS-1:0]  in_cmd,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [CODE_BITS-1:0] out_red,
	input logic [CODE_BITS-1:0] out_green,
	input logic [CODE_BITS-1:0] out_blue
);

	localparam logic [3:0] IdleLimit = 4'hf;

	logic [3:0]             pending_q;
	logic [3:0]             idle_q;
	logic                   in_take;
	logic                   px_take;
	logic                   out_take;
	logic [3*CODE_BITS-1:0] out_word;

	assign in_take  = in_valid && in_ready;
	assign px_take  = in_take && cmd_t'(in_cmd) == CMD_CONVERT;
	assign out_take = out_valid && out_ready;
	assign out_word = {out_red, out_green, out_blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			idle_q    <= '0;
		end else begin
			case ({px_take, out_take})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
			if (in_take) begin
				idle_q <= '0;
			end else if (idle_q != IdleLimit) begin
				idle_q <= idle_q + 1'b1;
			end
		end
	end

	`PCSC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`PCSC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_word))
	`PCSC_ASSERT_IMPLIES(a_no_phantom, clk, arst_n, out_valid, pending_q != '0)
	`PCSC_ASSERT_IMPLIES(a_drains, clk, arst_n, pending_q == '0 && idle_q == IdleLimit, in_ready)

endmodule

bind pixel_color_space_converter pcsc_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pixel.valid),
	.in_ready (pixel.ready),
	.in_cmd   (pixel.cmd),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_red  (result.out_red),
	.out_green(result.out_green),
	.out_blue (result.out_blue)
);
